FILE: rtl/core/sfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_pkg
// Types and constants shared by the sphere frustum cull core and its checker.
// ----------------------------------------------------------------------------
package sfc_pkg;

   localparam int PLANE_COUNT = 6;
   localparam int PLANE_IDX_W = 3;
   localparam int TERM_COUNT  = 3;
   localparam int COORD_W     = 16;
   localparam int RADIUS_W    = 15;
   localparam int FRAC_BITS   = 14;
   localparam int PROD_W      = 2 * COORD_W;
   localparam int DIST_W      = PROD_W + 1;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_LSB     = 3;

   typedef enum logic [1:0] {
      VERDICT_OUTSIDE    = 2'd0,
      VERDICT_INTERSECTS = 2'd1,
      VERDICT_INSIDE     = 2'd2
   } verdict_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]  center_x;
      logic signed [COORD_W-1:0]  center_y;
      logic signed [COORD_W-1:0]  center_z;
      logic [RADIUS_W-1:0]        sphere_radius;
      logic [PLANE_COUNT-1:0]     inside_mask;
      logic [PLANE_IDX_W-1:0]     entry_plane;
   } req_item_type;

   typedef struct packed {
      verdict_type                verdict;
      logic [PLANE_COUNT-1:0]     inside_mask_out;
      logic [PLANE_IDX_W-1:0]     start_plane_out;
   } rsp_item_type;

endpackage
`default_nettype wire

FILE: rtl/core/sphere_frustum_cull_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_frustum_cull_core
// Classifies one bounding sphere per cycle against six programmable planes.
// ----------------------------------------------------------------------------
// Takes one sphere on every cycle that start is high (busy is always low) and
// gives its result on rsp_item with rsp_strobe once the last stage is done; the
// receiver cannot stall, so results simply stream out in order. The four
// stages are: the eighteen 16x16 products of the plane normals with the
// centre, the distance sums with d scaled by 2^14, the compare of each
// distance against +/- radius*2^14, and the wrap-round walk from the start
// plane that picks the first rejecting plane and collects the inside bits.
// Planes sit at csr byte addresses 0x00..0x28 (a, b, c Q1.14 and d integer,
// 16 bits each from the bottom); the user must see that they are written only
// while no item is in flight, since the core itself does not enforce it.
module sphere_frustum_cull_core
   import sfc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_item_type          req_item,
   output logic                       rsp_strobe,
   output rsp_item_type               rsp_item,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   logic [CSR_DATA_W-1:0]         plane_ff [PLANE_COUNT];
   logic [PLANE_IDX_W-1:0]        csr_idx;

   logic signed [PROD_W-1:0]      prod_in  [PLANE_COUNT][TERM_COUNT];
   logic signed [PROD_W-1:0]      prod_ff  [PLANE_COUNT][TERM_COUNT];
   logic signed [DIST_W-1:0]      dist_in  [PLANE_COUNT];
   logic signed [DIST_W-1:0]      dist_ff  [PLANE_COUNT];
   logic signed [DIST_W-1:0]      rad_pos;
   logic signed [DIST_W-1:0]      rad_neg;
   logic [PLANE_COUNT-1:0]        ge_in, ge_ff;
   logic [PLANE_COUNT-1:0]        le_in, le_ff;

   req_item_type                  item1_ff, item2_ff, item3_ff;
   logic                          v1_ff, v2_ff, v3_ff;
   logic                          accept;

   rsp_item_type                  rsp_item_in;
   rsp_item_type                  rsp_item_ff;
   logic                          rsp_strobe_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;
   assign pready = 1'b1;

   // plane registers
   assign csr_idx = paddr[CSR_LSB +: PLANE_IDX_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PLANE_COUNT; p++) begin
            plane_ff[p] <= '0;
         end
      end else if (psel && penable && pwrite && pready &&
                   (csr_idx < PLANE_IDX_W'(PLANE_COUNT))) begin
         plane_ff[csr_idx] <= pwdata;
      end
   end

   always_comb begin
      if (csr_idx < PLANE_IDX_W'(PLANE_COUNT)) begin
         prdata = plane_ff[csr_idx];
      end else begin
         prdata = '0;
      end
   end

   // stage 1: products
   always_comb begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
         prod_in[p][0] = $signed(plane_ff[p][15:0])  * $signed(req_item.center_x);
         prod_in[p][1] = $signed(plane_ff[p][31:16]) * $signed(req_item.center_y);
         prod_in[p][2] = $signed(plane_ff[p][47:32]) * $signed(req_item.center_z);
      end
   end

   // stage 2: distance in Q.14
   always_comb begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
         dist_in[p] = DIST_W'(prod_ff[p][0]) + DIST_W'(prod_ff[p][1])
                    + DIST_W'(prod_ff[p][2])
                    + (DIST_W'($signed(plane_ff[p][63:48])) <<< FRAC_BITS);
      end
   end

   // stage 3: compare against the scaled radius
   assign rad_pos = DIST_W'(item2_ff.sphere_radius) << FRAC_BITS;
   assign rad_neg = -rad_pos;

   always_comb begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
         ge_in[p] = (dist_ff[p] >= rad_pos);
         le_in[p] = (dist_ff[p] <= rad_neg);
      end
   end

   // stage 4: walk the planes from the start plane, first reject wins
   always_comb begin
      logic [PLANE_IDX_W-1:0] first;
      logic [PLANE_IDX_W:0]   q;
      logic [PLANE_IDX_W-1:0] qi;
      logic [PLANE_IDX_W-1:0] reject;
      logic [PLANE_COUNT-1:0] mask;
      logic                   done;
      logic                   hit;

      if (item3_ff.entry_plane >= PLANE_IDX_W'(PLANE_COUNT)) begin
         first = item3_ff.entry_plane - PLANE_IDX_W'(PLANE_COUNT);
      end else begin
         first = item3_ff.entry_plane;
      end
      mask   = item3_ff.inside_mask;
      done   = 1'b0;
      hit    = 1'b0;
      reject = '0;
      q      = '0;
      qi     = '0;
      for (int k = 0; k < PLANE_COUNT; k++) begin
         q = {1'b0, first} + (PLANE_IDX_W + 1)'(k);
         if (q >= (PLANE_IDX_W + 1)'(PLANE_COUNT)) begin
            q = q - (PLANE_IDX_W + 1)'(PLANE_COUNT);
         end
         qi = q[PLANE_IDX_W-1:0];
         if (!done && !item3_ff.inside_mask[qi]) begin
            if (ge_ff[qi]) begin
               done   = 1'b1;
               reject = qi;
            end else if (le_ff[qi]) begin
               mask[qi] = 1'b1;
            end else begin
               hit = 1'b1;
            end
         end
      end

      rsp_item_in.inside_mask_out = mask;
      if (done) begin
         rsp_item_in.verdict         = VERDICT_OUTSIDE;
         rsp_item_in.start_plane_out = reject;
      end else begin
         rsp_item_in.verdict         = hit ? VERDICT_INTERSECTS : VERDICT_INSIDE;
         rsp_item_in.start_plane_out = item3_ff.entry_plane;
      end
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         v1_ff         <= accept;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         rsp_strobe_ff <= v3_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      item1_ff    <= req_item;
      dist_ff     <= dist_in;
      item2_ff    <= item1_ff;
      ge_ff       <= ge_in;
      le_ff       <= le_in;
      item3_ff    <= item2_ff;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule
`default_nettype wire

FILE: rtl/core/sfc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_checker
// Port-level checks on the sphere frustum cull core, bound into every instance of it.
// ----------------------------------------------------------------------------
module sfc_checker
   import sfc_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         start,
   input wire logic         busy,
   input wire req_item_type req_item,
   input wire logic         rsp_strobe,
   input wire rsp_item_type rsp_item
);

   // every accepted item gives a result on rsp_strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("item accepted but no result four cycles later");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 4))
      else $error("result without a matching item");

   // planes found inside only add to the mask
   a_mask_grows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (($past(req_item.inside_mask, 4) & ~rsp_item.inside_mask_out) == '0))
      else $error("result mask dropped an input mask bit");

   a_start_echo: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.verdict != VERDICT_OUTSIDE)) |->
         (rsp_item.start_plane_out == $past(req_item.entry_plane, 4)))
      else $error("start plane not echoed for a non-rejected sphere");

   // a rejecting plane is a real plane and was not skipped
   a_reject_plane: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.verdict == VERDICT_OUTSIDE)) |->
         ((rsp_item.start_plane_out < PLANE_IDX_W'(PLANE_COUNT)) &&
          !rsp_item.inside_mask_out[rsp_item.start_plane_out]))
      else $error("rejecting plane out of range or masked");

endmodule

bind sphere_frustum_cull_core sfc_checker u_sfc_checker (.*);
`default_nettype wire
